// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers for the FIR smoothing block; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define FSD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define FSD_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define FSD_ASSERT(lbl, clk, rst, prop, msg)
`define FSD_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// ----- design/fsd_pkg.sv -----
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared constants, types and the coefficient ROM of the FIR smoothing block.
// ----------------------------------------------------------------------------
package fsd_pkg;

   // fixed filter geometry
   localparam int TAPS           = 151;
   localparam int HALF_TAPS      = (TAPS + 1) / 2;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 14;
   localparam int COEF_FRAC_BITS = 20;
   localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS       = PROD_BITS + $clog2(TAPS);
   localparam int SP_W           = $clog2(TAPS + 1);

   // defaults for the top-level parameters
   localparam int DEF_SMOOTH_LENGTH = 51;
   localparam int DEF_DELAY_SLOTS   = 101;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_SMOOTH,
      ST_DIV,
      ST_FIX
   } fsd_state_type;

   // commands from the sequencer to the FIR unit
   typedef struct packed {
      logic            clr;
      logic [SP_W-1:0] clr_addr;
      logic            load;
   } fir_cmd_type;

   // status back from the FIR unit
   typedef struct packed {
      logic                   done;
      logic [SAMPLE_BITS-1:0] value;
   } fir_sts_type;

   // symmetric low-pass taps, units of 2^-20
   function automatic logic [COEF_BITS-1:0] coef_at(input logic [SP_W-1:0] k);
      logic [SP_W-1:0]      m;
      logic [COEF_BITS-1:0] c;
      m = (k < SP_W'(HALF_TAPS)) ? k : SP_W'(TAPS - 1) - k;
      case (m)
         8'd0:  c = 14'd358;   8'd1:  c = 14'd376;   8'd2:  c = 14'd399;   8'd3:  c = 14'd425;
         8'd4:  c = 14'd457;   8'd5:  c = 14'd495;   8'd6:  c = 14'd538;   8'd7:  c = 14'd588;
         8'd8:  c = 14'd645;   8'd9:  c = 14'd709;   8'd10: c = 14'd780;   8'd11: c = 14'd860;
         8'd12: c = 14'd948;   8'd13: c = 14'd1044;  8'd14: c = 14'd1150;  8'd15: c = 14'd1264;
         8'd16: c = 14'd1389;  8'd17: c = 14'd1522;  8'd18: c = 14'd1665;  8'd19: c = 14'd1819;
         8'd20: c = 14'd1982;  8'd21: c = 14'd2155;  8'd22: c = 14'd2338;  8'd23: c = 14'd2531;
         8'd24: c = 14'd2734;  8'd25: c = 14'd2947;  8'd26: c = 14'd3169;  8'd27: c = 14'd3401;
         8'd28: c = 14'd3642;  8'd29: c = 14'd3892;  8'd30: c = 14'd4150;  8'd31: c = 14'd4417;
         8'd32: c = 14'd4692;  8'd33: c = 14'd4974;  8'd34: c = 14'd5263;  8'd35: c = 14'd5559;
         8'd36: c = 14'd5860;  8'd37: c = 14'd6168;  8'd38: c = 14'd6479;  8'd39: c = 14'd6796;
         8'd40: c = 14'd7115;  8'd41: c = 14'd7438;  8'd42: c = 14'd7763;  8'd43: c = 14'd8089;
         8'd44: c = 14'd8416;  8'd45: c = 14'd8743;  8'd46: c = 14'd9069;  8'd47: c = 14'd9394;
         8'd48: c = 14'd9716;  8'd49: c = 14'd10035; 8'd50: c = 14'd10351; 8'd51: c = 14'd10662;
         8'd52: c = 14'd10967; 8'd53: c = 14'd11266; 8'd54: c = 14'd11557; 8'd55: c = 14'd11842;
         8'd56: c = 14'd12117; 8'd57: c = 14'd12384; 8'd58: c = 14'd12641; 8'd59: c = 14'd12886;
         8'd60: c = 14'd13121; 8'd61: c = 14'd13343; 8'd62: c = 14'd13553; 8'd63: c = 14'd13750;
         8'd64: c = 14'd13933; 8'd65: c = 14'd14102; 8'd66: c = 14'd14256; 8'd67: c = 14'd14396;
         8'd68: c = 14'd14520; 8'd69: c = 14'd14629; 8'd70: c = 14'd14720; 8'd71: c = 14'd14795;
         8'd72: c = 14'd14855; 8'd73: c = 14'd14897; 8'd74: c = 14'd14922;
         default: c = 14'd14931;  // center tap
      endcase
      return c;
   endfunction

endpackage

// ----- design/fir_smooth_and_delay_top.sv -----
// ----------------------------------------------------------------------------
// fir_smooth_and_delay_top
// Low-pass FIR of an envelope, running-average smoothing and a sample delay.
// ----------------------------------------------------------------------------
// Input words arrive on req_*: tdata carries a 16-bit unsigned sample, tuser the
// skip flag. A word with skip set is accepted and dropped without any effect.
// Each other word yields one word on rsp_*: the smoothed FIR output (low half)
// and the sample taken DELAY_SLOTS-1 samples earlier (high half).
// Timing: rsp_tvalid rises and req_tready returns in the same cycle, so a new
// sample is taken only after the previous one's result is loaded into the
// output register. The time per sample is set by the single multiply-accumulate
// walking the 151 taps out of the sample memory (one read per cycle) plus
// pipeline drain, sum update and the divide by SMOOTH_LENGTH. Skipped words go
// at one per cycle while the block is idle.
// Reset: a clearing pass over max(151, SMOOTH_LENGTH, DELAY_SLOTS) addresses
// zeroes the three memories; req_tready stays low meanwhile.
// Stall: the result is held in an output register; the next sample is taken
// while it waits, and its own result waits until rsp_tready frees the register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fir_smooth_and_delay_top #(
   parameter int SMOOTH_LENGTH = fsd_pkg::DEF_SMOOTH_LENGTH,
   parameter int DELAY_SLOTS   = fsd_pkg::DEF_DELAY_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // [0] skip
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [15:0] filtered, [31:16] delayed_sample
);
   import fsd_pkg::*;

   localparam int SM_W     = (SMOOTH_LENGTH > 1) ? $clog2(SMOOTH_LENGTH) : 1;
   localparam int DL_W     = $clog2(DELAY_SLOTS);
   localparam int SUM_W    = SAMPLE_BITS + ((SMOOTH_LENGTH > 1) ? $clog2(SMOOTH_LENGTH) : 0);
   localparam int NUM_W    = SUM_W + 1;
   localparam int HALF_LEN = SMOOTH_LENGTH / 2;
   localparam int SUM_MAX  = SMOOTH_LENGTH * ((1 << SAMPLE_BITS) - 1);
   localparam int RS       = 32;
   localparam logic [RS:0] RECIP = (RS + 1)'((64'd1 << RS) / SMOOTH_LENGTH);
   localparam int QP_W     = NUM_W + RS + 1;
   localparam int CLR_N    = (TAPS > SMOOTH_LENGTH)
                             ? ((TAPS > DELAY_SLOTS) ? TAPS : DELAY_SLOTS)
                             : ((SMOOTH_LENGTH > DELAY_SLOTS) ? SMOOTH_LENGTH : DELAY_SLOTS);
   localparam int CLR_W    = $clog2(CLR_N + 1);

   fsd_state_type          state_ff, state_in;
   logic [CLR_W-1:0]       clr_cnt_ff;
   logic [SM_W-1:0]        sm_pos_ff, sm_nxt;
   logic [DL_W-1:0]        dl_pos_ff, dl_nxt;
   logic [SUM_W-1:0]       sum_ff, sum_new;
   logic [NUM_W-1:0]       num_ff;
   logic [QP_W-1:0]        qprod_ff;
   logic [SAMPLE_BITS-1:0] sm_old_ff;
   logic [SAMPLE_BITS-1:0] dl_rd_ff;
   logic                   rsp_valid_ff;
   logic [31:0]            rsp_data_ff;

   logic [SAMPLE_BITS-1:0] sm_mem [SMOOTH_LENGTH];
   logic [SAMPLE_BITS-1:0] dl_mem [DELAY_SLOTS];

   logic                   accept;
   logic                   take;
   logic                   rsp_load;
   logic                   sm_we;
   logic [SM_W-1:0]        sm_wa;
   logic [SAMPLE_BITS-1:0] sm_wd;
   logic                   dl_we;
   logic [DL_W-1:0]        dl_wa;
   logic [SAMPLE_BITS-1:0] dl_wd;
   fir_cmd_type            fir_cmd;
   fir_sts_type            fir_sts;

   logic [SAMPLE_BITS-1:0] q_est;
   logic [NUM_W-1:0]       chk;
   logic [NUM_W-1:0]       rem;
   logic [SAMPLE_BITS-1:0] filt;

   assign accept = req_tvalid && req_tready;
   assign take   = accept && !req_tuser;
   assign sm_nxt = (sm_pos_ff == SM_W'(SMOOTH_LENGTH - 1)) ? '0 : sm_pos_ff + 1'b1;
   assign dl_nxt = (dl_pos_ff == DL_W'(DELAY_SLOTS - 1)) ? '0 : dl_pos_ff + 1'b1;

   fsd_fir u_fir (
      .clock  (clock),
      .reset  (reset),
      .cmd    (fir_cmd),
      .sample (req_tdata),
      .sts    (fir_sts)
   );

   // sequencer: next state and per-state controls
   always_comb begin
      state_in         = state_ff;
      req_tready       = 1'b0;
      rsp_load         = 1'b0;
      fir_cmd.clr      = 1'b0;
      fir_cmd.clr_addr = clr_cnt_ff[SP_W-1:0];
      fir_cmd.load     = 1'b0;
      sm_we            = 1'b0;
      sm_wa            = sm_pos_ff;
      sm_wd            = fir_sts.value;
      dl_we            = 1'b0;
      dl_wa            = dl_pos_ff;
      dl_wd            = req_tdata;
      unique case (state_ff)
         ST_CLEAR: begin
            fir_cmd.clr = clr_cnt_ff < CLR_W'(TAPS);
            sm_we       = clr_cnt_ff < CLR_W'(SMOOTH_LENGTH);
            sm_wa       = clr_cnt_ff[SM_W-1:0];
            sm_wd       = '0;
            dl_we       = clr_cnt_ff < CLR_W'(DELAY_SLOTS);
            dl_wa       = clr_cnt_ff[DL_W-1:0];
            dl_wd       = '0;
            if (clr_cnt_ff == CLR_W'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (take) begin
               fir_cmd.load = 1'b1;
               dl_we        = 1'b1;
               state_in     = ST_MAC;
            end
         end
         ST_MAC: begin
            if (fir_sts.done) begin
               state_in = ST_SMOOTH;
            end
         end
         ST_SMOOTH: begin
            sm_we    = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_FIX;
         end
         ST_FIX: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   // smoothing and delay memories; old entries read when the sample is taken
   always_ff @(posedge clock) begin
      if (sm_we) begin
         sm_mem[sm_wa] <= sm_wd;
      end
      if (take) begin
         sm_old_ff <= sm_mem[sm_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (dl_we) begin
         dl_mem[dl_wa] <= dl_wd;
      end
      if (take) begin
         dl_rd_ff <= dl_mem[dl_nxt];
      end
   end

   // ring positions and running sum
   assign sum_new = sum_ff - SUM_W'(sm_old_ff) + SUM_W'(fir_sts.value);

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_pos_ff <= '0;
         dl_pos_ff <= '0;
         sum_ff    <= '0;
      end else begin
         if (take) begin
            dl_pos_ff <= dl_nxt;
         end
         if (state_ff == ST_SMOOTH) begin
            sm_pos_ff <= sm_nxt;
            sum_ff    <= sum_new;
         end
      end
   end

   // divide by SMOOTH_LENGTH: reciprocal multiply, then one-step correction
   always_ff @(posedge clock) begin
      if (state_ff == ST_SMOOTH) begin
         num_ff <= NUM_W'(sum_new) + NUM_W'(HALF_LEN);
      end
      if (state_ff == ST_DIV) begin
         qprod_ff <= QP_W'(num_ff) * QP_W'(RECIP);
      end
   end

   always_comb begin
      q_est = qprod_ff[RS+SAMPLE_BITS-1:RS];
      chk   = NUM_W'(q_est) * NUM_W'(SMOOTH_LENGTH);
      rem   = num_ff - chk;
      filt  = (rem >= NUM_W'(SMOOTH_LENGTH)) ? q_est + 1'b1 : q_est;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {dl_rd_ff, filt};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `FSD_ASSERT(a_take_mac, clock, reset, take |=> state_ff == ST_MAC,
      "taken sample did not start the FIR")
   `FSD_ASSERT(a_done_mac, clock, reset, fir_sts.done |-> state_ff == ST_MAC,
      "FIR finished outside the MAC state")
   `FSD_ASSERT(a_sum_range, clock, reset, sum_ff <= SUM_W'(SUM_MAX),
      "running sum above its bound")
   `FSD_ASSERT(a_rsp_src, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff == ST_FIX),
      "result raised outside the final state")

endmodule

// ----- design/fsd_fir.sv -----
// ----------------------------------------------------------------------------
// fsd_fir
// 151-tap FIR: sample ring in a one-port-read memory and one shared MAC.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsd_fir (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fsd_pkg::fir_cmd_type                   cmd,
   input  logic [fsd_pkg::SAMPLE_BITS-1:0]        sample,
   output fsd_pkg::fir_sts_type                   sts
);
   import fsd_pkg::*;

   // sample ring
   logic [SAMPLE_BITS-1:0] ring_mem [TAPS];
   logic [SAMPLE_BITS-1:0] rdata_ff;

   logic [SP_W-1:0]        pos_ff;
   logic [SP_W-1:0]        pos_nxt;
   logic [SP_W-1:0]        rd_ptr_ff;
   logic [SP_W-1:0]        rd_nxt;
   logic [SP_W-1:0]        tap_ff;
   logic [SP_W-1:0]        k1_ff;
   logic                   busy_ff;
   logic                   v1_ff;
   logic                   v2_ff;
   logic                   done_ff;
   logic                   issue;
   logic                   finish;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [ACC_BITS-1:0]    acc_ff;
   logic [SAMPLE_BITS-1:0] fir_ff;
   logic [ACC_BITS:0]      rnd;
   logic [SAMPLE_BITS-1:0] sat;

   logic                   wr_en;
   logic [SP_W-1:0]        wr_addr;
   logic [SAMPLE_BITS-1:0] wr_data;

   assign pos_nxt = (pos_ff == SP_W'(TAPS - 1)) ? '0 : pos_ff + 1'b1;
   assign rd_nxt  = (rd_ptr_ff == SP_W'(TAPS - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign issue   = busy_ff && (tap_ff != SP_W'(TAPS));
   assign finish  = busy_ff && !issue && !v1_ff && !v2_ff;

   // write port: clearing pass or new sample
   always_comb begin
      wr_en   = cmd.clr || cmd.load;
      wr_addr = cmd.clr ? cmd.clr_addr : pos_ff;
      wr_data = cmd.clr ? '0 : sample;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rdata_ff <= ring_mem[rd_ptr_ff];
      end
   end

   // control: positions, tap counter, pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         rd_ptr_ff <= '0;
         tap_ff    <= '0;
         busy_ff   <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         v1_ff   <= issue;
         v2_ff   <= v1_ff;
         done_ff <= finish;
         if (cmd.load) begin
            pos_ff    <= pos_nxt;
            rd_ptr_ff <= pos_nxt;  // oldest sample meets the first tap
            tap_ff    <= '0;
            busy_ff   <= 1'b1;
         end else begin
            if (issue) begin
               rd_ptr_ff <= rd_nxt;
               tap_ff    <= tap_ff + 1'b1;
            end
            if (finish) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // multiply, then accumulate
   always_ff @(posedge clock) begin
      k1_ff <= tap_ff;
      if (v1_ff) begin
         prod_ff <= rdata_ff * coef_at(k1_ff);
      end
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_BITS'(prod_ff);
      end
      if (finish) begin
         fir_ff <= sat;
      end
   end

   // round half up and saturate
   always_comb begin
      rnd = (ACC_BITS + 1)'(acc_ff) + ((ACC_BITS + 1)'(1) << (COEF_FRAC_BITS - 1));
      if (|rnd[ACC_BITS:COEF_FRAC_BITS+SAMPLE_BITS]) begin
         sat = '1;
      end else begin
         sat = rnd[COEF_FRAC_BITS+SAMPLE_BITS-1:COEF_FRAC_BITS];
      end
   end

   assign sts.done  = done_ff;
   assign sts.value = fir_ff;

   `FSD_NEVER(a_load_busy, clock, reset, cmd.load && busy_ff, "FIR loaded while busy")
   `FSD_ASSERT(a_tap_range, clock, reset, tap_ff <= SP_W'(TAPS), "FIR tap count overran")
   `FSD_ASSERT(a_done_idle, clock, reset, busy_ff && finish |=> !busy_ff && done_ff,
      "FIR done without going idle")

endmodule
